>>> rtl/core/dmps_pkg.sv
// Shared types and constants for the diamond maximum path sum block.
`timescale 1ns / 1ps

package dmps_pkg;

  localparam int unsigned CELL_W = 15;
  localparam int unsigned SUM_W  = 23;
  localparam int unsigned SIDE_W = 8;

  // per-cell operand selection decided by the front end
  typedef struct packed {
    logic use_a;     // previous row at this column
    logic use_b;     // previous row at column + 1 (lower half)
    logic use_held;  // previous row at column - 1, held from the prior cell
    logic is_last;   // bottom cell: emit the diamond's result
  } dmps_ctl_t;

  localparam int unsigned CTL_W = $bits(dmps_ctl_t);

endpackage

>>> rtl/core/dmps_front.sv
// Front end: side register, row/column tracking and per-cell classification.
`timescale 1ns / 1ps

module dmps_front import dmps_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128,
  parameter int unsigned AW       = 7,
  parameter int unsigned RW       = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIDE_W-1:0] cfg_side_i,
  input  logic              in_valid_i,
  input  logic              q_full_i,
  input  logic [CELL_W-1:0] cell_value_i,
  output logic              in_ready_o,
  output logic              push_o,
  output dmps_ctl_t         ctl_o,
  output logic [AW-1:0]     col_o,
  output logic [CELL_W-1:0] value_o
);

  logic [RW-1:0] side_q, side_d;
  logic [RW-1:0] last_row_q, last_row_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] col_q, col_d;
  logic [31:0]   eff_side;
  logic [RW-1:0] col_ext;
  logic          upper;
  logic          row_end;
  logic          is_last;

  // clamp the side to 1..MAX_SIDE when it is written
  always_comb begin
    if (cfg_side_i == '0) begin
      eff_side = 32'd1;
    end else if (32'(cfg_side_i) > 32'(MAX_SIDE)) begin
      eff_side = 32'(MAX_SIDE);
    end else begin
      eff_side = 32'(cfg_side_i);
    end
    side_d     = eff_side[RW-1:0];
    last_row_d = RW'(2 * eff_side - 32'd2);
  end

  assign col_ext = RW'(col_q);
  assign upper   = (row_q < side_q);
  assign row_end = upper ? (col_ext == row_q) : (col_ext == (last_row_q - row_q));
  assign is_last = row_end && (row_q == last_row_q);

  assign in_ready_o     = !q_full_i;
  assign push_o         = in_valid_i && !q_full_i;
  assign ctl_o.use_a    = upper ? (col_ext != row_q) : 1'b1;
  assign ctl_o.use_b    = !upper;
  assign ctl_o.use_held = upper && (col_q != '0);
  assign ctl_o.is_last  = is_last;
  assign col_o          = col_q;
  assign value_o        = cell_value_i;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (push_o) begin
      if (is_last) begin
        row_d = '0;
        col_d = '0;
      end else if (row_end) begin
        row_d = row_q + 1'b1;
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= RW'(1);
      last_row_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        side_q     <= side_d;
        last_row_q <= last_row_d;
      end
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

>>> rtl/core/dmps_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module dmps_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/dmps_back.sv
// Back end: row-sum memory, add/max stage and result register.
`timescale 1ns / 1ps

module dmps_back import dmps_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128,
  parameter int unsigned AW       = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  dmps_ctl_t         head_ctl_i,
  input  logic [AW-1:0]     head_col_i,
  input  logic [CELL_W-1:0] head_value_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SUM_W-1:0]  best_sum_o
);

  logic [SUM_W-1:0]  row_mem_q [MAX_SIDE];

  logic              p1_valid_q;
  dmps_ctl_t         p1_ctl_q;
  logic [AW-1:0]     p1_col_q;
  logic [CELL_W-1:0] p1_value_q;

  logic [SUM_W-1:0]  rd_a_q, rd_b_q;
  logic              fwd_a_q, fwd_b_q;
  logic [SUM_W-1:0]  fwd_data_q;
  logic [SUM_W-1:0]  held_q;

  logic              out_valid_q;
  logic [SUM_W-1:0]  out_sum_q;

  logic [AW-1:0]     addr_b;
  logic              out_free;
  logic              advance;
  logic              fire;
  logic [SUM_W-1:0]  a_sel, b_sel, h_sel, best_ab, best, sum;

  assign addr_b   = head_col_i + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = !p1_valid_q || !p1_ctl_q.is_last || out_free;
  assign pop_o    = !q_empty_i && advance;
  assign fire     = p1_valid_q && advance;

  // the cell ahead writes at the same edge the next reads are taken: bypass it
  assign a_sel   = !p1_ctl_q.use_a    ? '0 : (fwd_a_q ? fwd_data_q : rd_a_q);
  assign b_sel   = !p1_ctl_q.use_b    ? '0 : (fwd_b_q ? fwd_data_q : rd_b_q);
  assign h_sel   = !p1_ctl_q.use_held ? '0 : held_q;
  assign best_ab = (a_sel > b_sel) ? a_sel : b_sel;
  assign best    = (best_ab > h_sel) ? best_ab : h_sel;
  assign sum     = SUM_W'(p1_value_q) + best;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      row_mem_q[p1_col_q] <= sum;
      held_q              <= a_sel;
    end
    if (pop_o) begin
      rd_a_q     <= row_mem_q[head_col_i];
      rd_b_q     <= row_mem_q[addr_b];
      fwd_a_q    <= fire && (p1_col_q == head_col_i);
      fwd_b_q    <= fire && (p1_col_q == addr_b);
      fwd_data_q <= sum;
    end
    if (advance) begin
      p1_ctl_q   <= head_ctl_i;
      p1_col_q   <= head_col_i;
      p1_value_q <= head_value_i;
    end
    if (fire && p1_ctl_q.is_last) begin
      out_sum_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        p1_valid_q <= pop_o;
      end
      if (fire && p1_ctl_q.is_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_sum_o  = out_sum_q;

endmodule

>>> rtl/core/diamond_max_path_sum.sv
// Top level of the diamond maximum path sum engine.
`timescale 1ns / 1ps

// Streams the cells of a diamond grid (side n: rows of 1..n cells, then n-1..1)
// one cell per transaction, top row first, left to right, and returns one
// transaction carrying the best top-to-bottom path sum after the bottom cell,
// then starts the next diamond. The side register takes 1..MAX_SIDE; 0 acts as
// 1 and larger values clamp to MAX_SIDE, and any write abandons a diamond in
// progress, so write it only while the block is idle. Throughput is one cell
// per clock when nothing stalls: the front end counts rows and columns and tags
// each cell, a two-entry queue decouples it from the back end, and the back end
// reads the previous row from a MAX_SIDE-deep memory through two registered
// read ports, adds, and writes the new sum back in place, with a bypass for
// the sum just written. A result passes from the queue through the add stage
// into the result register; that register lets input keep flowing while a
// finished result waits, until the next bottom cell reaches the add stage.
module diamond_max_path_sum import dmps_pkg::*; #(
  parameter int unsigned MAX_SIDE = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIDE_W-1:0] side_length_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CELL_W-1:0] cell_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SUM_W-1:0]  best_sum_o
);

  // column address and row counter widths
  localparam int unsigned AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned RW = (MAX_SIDE > 1) ? $clog2(2 * MAX_SIDE) : 1;
  localparam int unsigned QW = CTL_W + AW + CELL_W;

  logic              cfg_we;
  logic              q_push, q_pop, q_full, q_empty;
  dmps_ctl_t         f_ctl, h_ctl;
  logic [AW-1:0]     f_col, h_col;
  logic [CELL_W-1:0] f_value, h_value;
  logic [QW-1:0]     q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  dmps_front #(
    .MAX_SIDE (MAX_SIDE),
    .AW       (AW),
    .RW       (RW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_side_i   (side_length_i),
    .in_valid_i   (in_valid_i),
    .q_full_i     (q_full),
    .cell_value_i (cell_value_i),
    .in_ready_o   (in_ready_o),
    .push_o       (q_push),
    .ctl_o        (f_ctl),
    .col_o        (f_col),
    .value_o      (f_value)
  );

  assign q_wdata = {f_ctl, f_col, f_value};

  dmps_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign h_ctl   = dmps_ctl_t'(q_rdata[QW-1 -: CTL_W]);
  assign h_col   = q_rdata[CELL_W +: AW];
  assign h_value = q_rdata[CELL_W-1:0];

  dmps_back #(
    .MAX_SIDE (MAX_SIDE),
    .AW       (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_ctl_i   (h_ctl),
    .head_col_i   (h_col),
    .head_value_i (h_value),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_sum_o   (best_sum_o)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // a fresh result must follow a cell popped into the add stage before it
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(q_pop, 2))
    else $error("result without a preceding cell");

endmodule
